/* hw/rtl/bmp24_to_rgb565_decoder_defines.svh */
// Assertion macros shared by the BMP decoder RTL.
`ifndef BMP24_TO_RGB565_DECODER_DEFINES_SVH
`define BMP24_TO_RGB565_DECODER_DEFINES_SVH

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define BMP_ASSERT_IMPL(label, ante, cons) \
label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("bmp decoder assertion failed");

// Whenever the antecedent holds, the consequent holds in the next cycle.
`define BMP_ASSERT_NEXT(label, ante, cons) \
label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("bmp decoder assertion failed");

`endif

/* hw/rtl/bmp_pkg.sv */
// Package with the word types and constants of the BMP decoder.
`default_nettype none

package bmp_pkg;

	// Input word: one byte of the file and the start-of-file flag.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       file_start;
	} bmp_in_t;

	// Result word: a pixel or a status code.
	typedef struct packed {
		logic [2:0]        kind;
		logic [15:0]       pixel;
		logic signed [15:0] column;
		logic signed [15:0] row;
		logic              last;
	} bmp_out_t;

	// Result kinds.
	localparam logic [2:0] KIND_PIXEL   = 3'd0;
	localparam logic [2:0] KIND_BAD_SIG = 3'd1;
	localparam logic [2:0] KIND_FORMAT  = 3'd2;
	localparam logic [2:0] KIND_OFFSET  = 3'd3;
	localparam logic [2:0] KIND_EMPTY   = 3'd4;

	// Configuration register indexes.
	localparam logic CFG_ORIGIN_X = 1'b0;
	localparam logic CFG_ORIGIN_Y = 1'b1;

	// Header constants.
	localparam logic [7:0]  SIG_BYTE0  = 8'h42;
	localparam logic [7:0]  SIG_BYTE1  = 8'h4D;
	localparam logic [7:0]  PLANES_ONE = 8'd1;
	localparam logic [7:0]  BPP_24     = 8'd24;
	localparam logic [31:0] HEADER_END = 32'd34;

endpackage

`default_nettype wire

/* hw/rtl/bmp_parser.sv */
// Header parser and pixel assembler of the BMP decoder, one byte per cycle while take is high.
`default_nettype none

`include "bmp24_to_rgb565_decoder_defines.svh"

module bmp_parser
	import bmp_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              take,
	input  wire bmp_in_t           in_word,
	input  wire logic signed [15:0] origin_x,
	input  wire logic signed [15:0] origin_y,
	output logic                   res_valid,
	output bmp_out_t               res_word
);

	localparam logic [2:0] PH_IDLE   = 3'd0;
	localparam logic [2:0] PH_HEADER = 3'd1;
	localparam logic [2:0] PH_SKIP   = 3'd2;
	localparam logic [2:0] PH_PIXELS = 3'd3;
	localparam logic [2:0] PH_PAD    = 3'd4;

	typedef struct packed {
		logic [2:0]  phase;
		logic [31:0] pos;
		logic [31:0] offset;
		logic [15:0] width;
		logic [15:0] height;
		logic [15:0] col;
		logic [15:0] rows;
		logic [15:0] row;
		logic [1:0]  bip;
		logic [7:0]  blue;
		logic [7:0]  green;
		logic [1:0]  pad;
		logic        sig_ok;
		logic        fmt_bad;
	} pstate_t;

	pstate_t     st_q;
	pstate_t     st_c;
	pstate_t     st_d;
	logic [7:0]  b;
	logic [7:0]  want;
	logic        fmt_bad_nx;
	logic [15:0] col_inc;
	logic [31:0] pos_inc;
	logic [1:0]  pad_dec;

	assign b = in_word.data_byte;

	always_comb begin
		st_c = st_q;
		if (take && in_word.file_start) begin
			st_c = '0;
			st_c.phase = PH_HEADER;
		end
		st_d = st_c;
		res_valid = 1'b0;
		res_word = '0;
		col_inc = st_c.col + 16'd1;
		pos_inc = (st_c.pos == 32'hFFFF_FFFF) ? st_c.pos : st_c.pos + 32'd1;
		pad_dec = (st_c.pad != 2'd0) ? st_c.pad - 2'd1 : 2'd0;
		want = 8'd0;
		if (st_c.pos == 32'd26) begin
			want = PLANES_ONE;
		end else if (st_c.pos == 32'd28) begin
			want = BPP_24;
		end
		fmt_bad_nx = st_c.fmt_bad;
		if (st_c.pos >= 32'd26 && st_c.pos <= 32'd33 && b != want) begin
			fmt_bad_nx = 1'b1;
		end

		if (take) begin
			unique case (st_c.phase)
				PH_HEADER: begin
					st_d.pos = st_c.pos + 32'd1;
					st_d.fmt_bad = fmt_bad_nx;
					case (st_c.pos)
						32'd0: st_d.sig_ok = (b == SIG_BYTE0);
						32'd1: begin
							if (!(st_c.sig_ok && b == SIG_BYTE1)) begin
								res_valid = 1'b1;
								res_word.kind = KIND_BAD_SIG;
								res_word.last = 1'b1;
								st_d.phase = PH_IDLE;
							end
						end
						32'd10: st_d.offset[7:0] = b;
						32'd11: st_d.offset[15:8] = b;
						32'd12: st_d.offset[23:16] = b;
						32'd13: st_d.offset[31:24] = b;
						32'd18: st_d.width[7:0] = b;
						32'd19: st_d.width[15:8] = b;
						32'd22: st_d.height[7:0] = b;
						32'd23: st_d.height[15:8] = b;
						default: ;
					endcase
					if (st_c.pos == HEADER_END - 32'd1) begin
						if (fmt_bad_nx) begin
							res_valid = 1'b1;
							res_word.kind = KIND_FORMAT;
							res_word.last = 1'b1;
							st_d.phase = PH_IDLE;
						end else if (st_c.offset < HEADER_END) begin
							res_valid = 1'b1;
							res_word.kind = KIND_OFFSET;
							res_word.last = 1'b1;
							st_d.phase = PH_IDLE;
						end else if (st_c.width == 16'd0 || st_c.height == 16'd0) begin
							res_valid = 1'b1;
							res_word.kind = KIND_EMPTY;
							res_word.last = 1'b1;
							st_d.phase = PH_IDLE;
						end else begin
							st_d.rows = st_c.height;
							st_d.row = 16'(origin_y + st_c.height - 16'd1);
							st_d.col = 16'd0;
							st_d.bip = 2'd0;
							st_d.phase = (st_c.offset == HEADER_END) ? PH_PIXELS : PH_SKIP;
						end
					end
				end
				PH_SKIP: begin
					st_d.pos = pos_inc;
					if (pos_inc >= st_c.offset) begin
						st_d.phase = PH_PIXELS;
					end
				end
				PH_PIXELS: begin
					case (st_c.bip)
						2'd0: begin
							st_d.blue = b;
							st_d.bip = 2'd1;
						end
						2'd1: begin
							st_d.green = b;
							st_d.bip = 2'd2;
						end
						default: begin
							st_d.bip = 2'd0;
							res_valid = 1'b1;
							res_word.kind = KIND_PIXEL;
							res_word.pixel = {b[7:3], st_c.green[7:2], st_c.blue[7:3]};
							res_word.column = 16'(origin_x + st_c.col);
							res_word.row = st_c.row;
							st_d.col = col_inc;
							if (col_inc == st_c.width) begin
								if (st_c.rows <= 16'd1) begin
									st_d.rows = 16'd0;
									res_word.last = 1'b1;
									st_d.phase = PH_IDLE;
								end else begin
									st_d.rows = st_c.rows - 16'd1;
									st_d.row = st_c.row - 16'd1;
									st_d.col = 16'd0;
									st_d.pad = st_c.width[1:0];
									if (st_c.width[1:0] != 2'd0) begin
										st_d.phase = PH_PAD;
									end
								end
							end
						end
					endcase
				end
				PH_PAD: begin
					st_d.pad = pad_dec;
					if (pad_dec == 2'd0) begin
						st_d.phase = PH_PIXELS;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else begin
			st_q <= st_d;
		end
	end

	`BMP_ASSERT_IMPL(a_res_needs_take, res_valid, take)
	`BMP_ASSERT_NEXT(a_status_goes_idle, res_valid && res_word.kind != KIND_PIXEL, st_q.phase == PH_IDLE)
	`BMP_ASSERT_NEXT(a_pixel_keeps_image, res_valid && res_word.kind == KIND_PIXEL && !res_word.last, st_q.phase == PH_PIXELS || st_q.phase == PH_PAD)

endmodule

`default_nettype wire

/* hw/rtl/bmp_res_buf.sv */
// Two-entry result buffer between the parser and the result channel.
`default_nettype none

`include "bmp24_to_rgb565_decoder_defines.svh"

module bmp_res_buf
	import bmp_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  wire bmp_out_t push_word,
	output logic          space,
	output logic          res_valid,
	input  wire logic     res_ready,
	output bmp_out_t      res_word
);

	bmp_out_t   slot_q [2];
	logic [1:0] count_q;
	logic       pop;
	logic [1:0] wr_idx;

	assign pop = res_valid && res_ready;
	assign space = (count_q != 2'd2);
	assign res_valid = (count_q != 2'd0);
	assign res_word = slot_q[0];
	assign wr_idx = count_q - {1'b0, pop};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else begin
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	// The head shifts forward on a pop; a push lands behind what remains.
	always_ff @(posedge clk) begin
		if (push && wr_idx == 2'd0) begin
			slot_q[0] <= push_word;
		end else if (pop) begin
			slot_q[0] <= slot_q[1];
		end
		if (push && wr_idx == 2'd1) begin
			slot_q[1] <= push_word;
		end
	end

	`BMP_ASSERT_IMPL(a_no_overflow, push, count_q != 2'd2)
	`BMP_ASSERT_IMPL(a_count_range, 1'b1, count_q != 2'd3)
	`BMP_ASSERT_NEXT(a_push_shows, push && count_q == 2'd0, res_valid)

endmodule

`default_nettype wire

/* hw/rtl/bmp24_to_rgb565_decoder.sv */
// Top level of the streaming 24-bit BMP to RGB565 decoder.
`default_nettype none

// The decoder takes a BMP file one byte word per cycle on the byte channel and
// delivers RGB565 pixels with screen coordinates, or a single status word, on
// the result channel. A word with file_start set restarts the parser at byte
// zero in any state. Each byte is handled in the cycle it is accepted, so the
// rate is one byte per cycle while byte_ready is high; a pixel enters the
// result buffer as its red byte is accepted. Results pass through a two-entry
// buffer, and byte_ready drops only while both entries hold results that the
// consumer has not yet taken. Rows are delivered bottom-up as the file stores
// them, starting at origin_y plus height minus one, and last marks the final
// pixel and every status word. origin_x is applied live to each pixel, while
// origin_y is sampled when the header completes; write them while idle.

module bmp24_to_rgb565_decoder
	import bmp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        byte_valid,
	output logic             byte_ready,
	input  wire bmp_in_t     byte_word,
	output logic             res_valid,
	input  wire logic        res_ready,
	output bmp_out_t         res_word,
	input  wire logic        cfg_we,
	input  wire logic        cfg_addr,
	input  wire logic [15:0] cfg_data
);

	logic signed [15:0] origin_x_q;
	logic signed [15:0] origin_y_q;
	logic               take;
	logic               par_valid;
	bmp_out_t           par_word;
	logic               buf_space;

	// Configuration registers: a write lands at the clock edge with cfg_we high.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= '0;
			origin_y_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_ORIGIN_X: origin_x_q <= cfg_data;
				CFG_ORIGIN_Y: origin_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// A byte is taken whenever the result buffer has a free entry, so the
	// result it may cause always has somewhere to go.
	assign byte_ready = buf_space;
	assign take = byte_valid && byte_ready;

	// The parser updates its state and forms at most one result per byte.
	bmp_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.in_word   (byte_word),
		.origin_x  (origin_x_q),
		.origin_y  (origin_y_q),
		.res_valid (par_valid),
		.res_word  (par_word)
	);

	// The buffer registers each result and decouples the consumer's stalls.
	bmp_res_buf u_res_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (par_valid),
		.push_word (par_word),
		.space     (buf_space),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_word  (res_word)
	);

endmodule

`default_nettype wire
